### rtl/fpt_pkg.sv
package fpt_pkg;

	// Default sizing for the top level parameters.
	localparam int RUN_COUNTER_BITS_DEF = 8;
	localparam int COS_TABLE_DEPTH_DEF  = 1024;

	// Phase codes.
	localparam logic [1:0] PHASE_FLIGHT  = 2'd0;
	localparam logic [1:0] PHASE_DESCENT = 2'd1;
	localparam logic [1:0] PHASE_GROUND  = 2'd2;

	// Event codes carried by the onboard and remote fields.
	localparam logic [1:0] EVT_APOGEE    = 2'd0;
	localparam logic [1:0] EVT_TOUCHDOWN = 2'd1;

	// Configuration register indexes and widths.
	localparam int         CFG_INDEX_W              = 1;
	localparam int         CFG_DATA_W               = 8;
	localparam logic [0:0] CFG_APOGEE_RUN_THRESHOLD = 1'd0;
	localparam logic [0:0] CFG_REMOTE_EVENTS_ENABLE = 1'd1;
	localparam logic [7:0] APOGEE_RUN_THRESHOLD_RST = 8'd5;
	localparam logic       REMOTE_EVENTS_ENABLE_RST = 1'b1;

	// Angle folding limits, in hundredths of a degree.
	localparam logic [15:0] DEG_FULL    = 16'd36000;
	localparam logic [15:0] DEG_HALF    = 16'd18000;
	localparam logic [15:0] DEG_QUARTER = 16'd9000;
	localparam int          DEG_QUARTER_INT = 9000;
	localparam int          DEG_EIGHTH_INT  = 4500;

	// Fixed point constants: cosine magnitudes are Q15 with 1.0 = 32768.
	localparam int          COS_W         = 16;
	localparam logic [31:0] TILT_LIMIT    = 32'd23170 * 32'd32768;
	localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
	localparam logic [63:0] ONE_Q30       = 64'd1073741824;
	localparam logic [63:0] COS_SERIES_DIV [8] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
	};

	typedef struct packed {
		logic signed [15:0] roll_tilt;
		logic signed [15:0] pitch_tilt;
		logic [1:0]         onboard_event;
		logic [1:0]         remote_event;
	} sample_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       tilt_apogee;
		logic [7:0] tilt_run;
	} result_t;

	// Cosine of a Q30 angle in radians (0 to pi/2), by a nine term Taylor series,
	// rounded to a Q15 magnitude. Used only to build the constant table.
	function automatic logic [COS_W-1:0] cos_series(input logic [63:0] t);
		logic [63:0] t2;
		logic [63:0] term;
		longint      sum;
		logic [63:0] rounded;
		t2   = (t * t) >> 30;
		term = ONE_Q30;
		sum  = longint'(ONE_Q30);
		for (int k = 0; k < 8; k++) begin
			term = (term * t2) >> 30;
			term = term / COS_SERIES_DIV[k];
			if ((k % 2) == 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		rounded = (64'(sum) + 64'd16384) >> 15;
		return rounded[COS_W-1:0];
	endfunction

	// Next phase after one event code; anything but a legal transition holds.
	function automatic logic [1:0] apply_event(input logic [1:0] ph, input logic [1:0] code);
		logic [1:0] nxt;
		nxt = ph;
		if (code == EVT_APOGEE && ph == PHASE_FLIGHT) begin
			nxt = PHASE_DESCENT;
		end else if (code == EVT_TOUCHDOWN && ph == PHASE_DESCENT) begin
			nxt = PHASE_GROUND;
		end
		return nxt;
	endfunction

endpackage

### rtl/flight_phase_tracker_core.sv
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   sample_t (two angles, two event codes)
// result    out        result_valid / result_ready   result_t (phase, tilt_apogee, tilt_run)
// cfg       in         cfg_we (no wait)              cfg_index, cfg_data
//
// One transaction per cycle sustained while result_ready stays high; a sample passes the input
// register, the fold stage, the cosine ROM read and then the state update into the output
// register before result_valid rises. The two cosine lookups share one ROM with two read ports.
// Reset sets flight phase, a zero run count and the register defaults; the ROM is
// constant, so no clearing pass follows reset. A stalled result holds only the stages
// behind it: each stage takes new data whenever it is empty or the next stage moves on.
module flight_phase_tracker_core
	import fpt_pkg::*;
#(
	parameter int RUN_COUNTER_BITS = RUN_COUNTER_BITS_DEF,
	parameter int COS_TABLE_DEPTH  = COS_TABLE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  sample_t                sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
	localparam int QTR_W = 14;
	localparam longint N_MAX = longint'(DEG_QUARTER_INT) * COS_TABLE_DEPTH + DEG_EIGHTH_INT;
	localparam int N_W = $clog2(N_MAX + 1);
	// Reciprocal of the quarter turn, exact for every numerator below 2^N_W.
	localparam int RECIP_SH = N_W + QTR_W;
	localparam logic [63:0] RECIP_M =
		((64'd1 << RECIP_SH) + 64'(DEG_QUARTER_INT) - 64'd1) / 64'(DEG_QUARTER_INT);
	localparam int PROD_W = RECIP_SH + IDX_W + 1;
	localparam int CMP_W = (RUN_COUNTER_BITS > 8) ? RUN_COUNTER_BITS : 8;
	localparam logic [RUN_COUNTER_BITS-1:0] RUN_MAX = '1;

	typedef logic [COS_W-1:0] cos_rom_t [0:COS_TABLE_DEPTH];

	// Quarter-wave table: entry i is cos(i * 90 / depth degrees) in Q15.
	function automatic cos_rom_t build_cos_rom();
		cos_rom_t rom;
		for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
			rom[i] = cos_series((64'(i) * HALF_PI_Q30) / COS_TABLE_DEPTH);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

	typedef struct packed {
		logic             neg;
		logic [N_W-1:0]   num;
	} fold_t;

	// Fold an angle onto the first quadrant and form the rounding numerator.
	function automatic fold_t fold_angle(input logic signed [15:0] a);
		fold_t       f;
		logic [15:0] mag;
		logic [15:0] quad;
		mag = a[15] ? 16'(-a) : 16'(a);
		if (mag > DEG_HALF) begin
			mag = DEG_FULL - mag;
		end
		f.neg = 1'b0;
		quad  = mag;
		if (mag > DEG_QUARTER) begin
			f.neg = 1'b1;
			quad  = DEG_HALF - mag;
		end
		f.num = N_W'(quad[QTR_W-1:0]) * N_W'(COS_TABLE_DEPTH) + N_W'(DEG_EIGHTH_INT);
		return f;
	endfunction

	// Table index: numerator divided by the quarter turn via reciprocal multiply.
	function automatic logic [IDX_W-1:0] table_index(input logic [N_W-1:0] num);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(num) * PROD_W'(RECIP_M);
		return prod[RECIP_SH +: IDX_W];
	endfunction

	// Pipeline state.
	logic                        v_s1, v_s2, v_s3, v_s4;
	logic                        rdy_s2, rdy_s3, rdy_s4;
	sample_t                     smp_s1;
	fold_t                       fx_s2, fy_s2;
	logic [1:0]                  onb_s2, rem_s2, onb_s3, rem_s3;
	logic                        negx_s3, negy_s3;
	logic [COS_W-1:0]            cx_s3, cy_s3;
	result_t                     res_s4;

	// Architectural state and configuration.
	logic [1:0]                  phase_q;
	logic [RUN_COUNTER_BITS-1:0] count_q;
	logic [7:0]                  thresh_q;
	logic                        remote_en_q;

	fold_t                       fx, fy;
	logic [IDX_W-1:0]            idx_x, idx_y;
	logic [2*COS_W-1:0]          cos_prod;
	logic                        tilted;
	logic [1:0]                  phase_d;
	logic [RUN_COUNTER_BITS-1:0] count_d;
	logic                        apogee_d;
	logic                        commit;

	// Ready chain: a stage takes data when it is empty or its successor moves.
	assign rdy_s4       = !v_s4 || result_ready;
	assign rdy_s3       = !v_s3 || rdy_s4;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign sample_ready = !v_s1 || rdy_s2;
	assign commit       = v_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (sample_ready) v_s1 <= sample_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (sample_ready) begin
			smp_s1 <= sample;
		end
	end

	// Fold both angles and register the rounding numerators.
	assign fx = fold_angle(smp_s1.roll_tilt);
	assign fy = fold_angle(smp_s1.pitch_tilt);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			fx_s2  <= fx;
			fy_s2  <= fy;
			onb_s2 <= smp_s1.onboard_event;
			rem_s2 <= smp_s1.remote_event;
		end
	end

	// Index the cosine ROM; the read data is registered.
	assign idx_x = table_index(fx_s2.num);
	assign idx_y = table_index(fy_s2.num);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			cx_s3   <= COS_ROM[idx_x];
			cy_s3   <= COS_ROM[idx_y];
			negx_s3 <= fx_s2.neg;
			negy_s3 <= fy_s2.neg;
			onb_s3  <= onb_s2;
			rem_s3  <= rem_s2;
		end
	end

	// Tilt test: a product of opposite sign is never above the limit.
	assign cos_prod = cx_s3 * cy_s3;
	assign tilted   = (negx_s3 ^ negy_s3) || (cos_prod <= TILT_LIMIT);

	// Run counter and tilt apogee (in flight only), then onboard and remote (when enabled) events in that order.
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		apogee_d = 1'b0;
		if (phase_q == PHASE_FLIGHT) begin
			if (tilted) begin
				count_d = (count_q == RUN_MAX) ? count_q : count_q + 1'b1;
			end else begin
				count_d = '0;
			end
			if (CMP_W'(count_d) >= CMP_W'(thresh_q)) begin
				apogee_d = 1'b1;
				phase_d  = apply_event(phase_d, EVT_APOGEE);
			end
		end
		phase_d = apply_event(phase_d, onb_s3);
		if (remote_en_q) begin
			phase_d = apply_event(phase_d, rem_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_FLIGHT;
			count_q <= '0;
		end else if (commit) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (commit) begin
			res_s4.phase       <= phase_d;
			res_s4.tilt_apogee <= apogee_d;
			res_s4.tilt_run    <= 8'(CMP_W'(count_d));
		end
	end

	assign result_valid = v_s4;
	assign result       = res_s4;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q    <= APOGEE_RUN_THRESHOLD_RST;
			remote_en_q <= REMOTE_EVENTS_ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_APOGEE_RUN_THRESHOLD: begin
					thresh_q <= cfg_data[7:0];
				end
				CFG_REMOTE_EVENTS_ENABLE: begin
					remote_en_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
